[src/bmp24_stream_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the BMP stream decoder
// Concurrent checks are sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_DECODER_UNIT_MACROS_SVH
`define BMP24_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication check.
`define BMP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication check.
`define BMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define BMP_ASSERT_NOW(lbl, ante, cons)
`define BMP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/bmp24_pkg.sv]
// ----------------------------------------------------------------------------
// BMP stream decoder package
// Shared widths, parameter defaults and status codes.
// ----------------------------------------------------------------------------
package bmp24_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Width of the row and column fields of a pixel result.
	localparam int POS_W = 12;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIG   = 3'd1;
	localparam logic [2:0] ST_BAD_HSIZE = 3'd2;
	localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
	localparam logic [2:0] ST_COMPRESS  = 3'd4;
	localparam logic [2:0] ST_BAD_DIM   = 3'd5;

	localparam logic EV_PIXEL  = 1'b0;
	localparam logic EV_HEADER = 1'b1;

endpackage

[src/bmp24_stream_decoder_unit.sv]
// Order: an accepted byte is held in the input register, and its result, if any, is
// loaded into the result register when that register is empty or draining.
// Throughput: one byte per cycle while result_stall does not hold a pending result; the
// whole parse step for a byte fits between the input register and the result register.
// Reset: arst_n low clears the parser to idle and empties both registers at once.
// ----------------------------------------------------------------------------
// BMP 24-bit stream decoder
// Checks the 54-byte header of an uncompressed 24-bit BMP stream, reports a
// status result, then turns each BGR byte triple into an RGB pixel result and
// drops the row padding.
// ----------------------------------------------------------------------------
`include "bmp24_stream_decoder_unit_macros.svh"

module bmp24_stream_decoder_unit
	import bmp24_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [7:0]       data_byte,
	input  logic             start_of_file,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             event_kind,
	output logic [2:0]       status_code,
	output logic             planes_warning,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [POS_W-1:0] pixel_row,
	output logic [POS_W-1:0] pixel_column,
	output logic             last_pixel
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = POS_W + 1;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Header byte offsets at which a field is complete.
	localparam logic [5:0] OFS_SIG    = 6'd1;
	localparam logic [5:0] OFS_HSIZE  = 6'd17;
	localparam logic [5:0] OFS_WIDTH  = 6'd21;
	localparam logic [5:0] OFS_HEIGHT = 6'd25;
	localparam logic [5:0] OFS_PLANES = 6'd27;
	localparam logic [5:0] OFS_DEPTH  = 6'd29;
	localparam logic [5:0] OFS_COMPR  = 6'd33;
	localparam logic [5:0] OFS_LAST   = 6'd53;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;

	// Parser state
	logic [1:0]       phase_q;
	logic [5:0]       idx_q;
	logic [31:0]      shift_q;
	logic [2:0]       stat_q;
	logic             plane_q;
	logic [WW-1:0]    width_q;
	logic [HW-1:0]    height_q;
	logic [1:0]       comp_q;
	logic [7:0]       blue_q;
	logic [7:0]       green_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [1:0]       pad_q;

	logic [1:0]       phase_n;
	logic [5:0]       idx_n;
	logic [31:0]      shift_n;
	logic [2:0]       stat_n;
	logic             plane_n;
	logic [WW-1:0]    width_n;
	logic [HW-1:0]    height_n;
	logic [1:0]       comp_n;
	logic [7:0]       blue_n;
	logic [7:0]       green_n;
	logic [POS_W-1:0] col_n;
	logic [POS_W-1:0] row_n;
	logic [1:0]       pad_n;

	// Result of the current step
	logic             produce;
	logic             r_kind;
	logic [2:0]       r_status;
	logic             r_plane;
	logic [7:0]       r_red;
	logic [7:0]       r_green;
	logic [7:0]       r_blue;
	logic [POS_W-1:0] r_row;
	logic [POS_W-1:0] r_col;
	logic             r_last;

	logic [CW-1:0] col_inc;
	logic [CW-1:0] row_inc;
	logic          advance;

	// A registered byte moves on whenever the result slot is empty or draining.
	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	assign col_inc = CW'(col_q) + CW'(1);
	assign row_inc = CW'(row_q) + CW'(1);

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		shift_n  = shift_q;
		stat_n   = stat_q;
		plane_n  = plane_q;
		width_n  = width_q;
		height_n = height_q;
		comp_n   = comp_q;
		blue_n   = blue_q;
		green_n  = green_q;
		col_n    = col_q;
		row_n    = row_q;
		pad_n    = pad_q;

		produce  = 1'b0;
		r_kind   = EV_PIXEL;
		r_status = ST_OK;
		r_plane  = 1'b0;
		r_red    = '0;
		r_green  = '0;
		r_blue   = '0;
		r_row    = '0;
		r_col    = '0;
		r_last   = 1'b0;

		// A start byte wipes the previous file and is header byte zero.
		if (sof_s1) begin
			phase_n  = PH_HEADER;
			idx_n    = '0;
			shift_n  = '0;
			stat_n   = ST_OK;
			plane_n  = 1'b0;
			width_n  = '0;
			height_n = '0;
			comp_n   = '0;
			blue_n   = '0;
			green_n  = '0;
			col_n    = '0;
			row_n    = '0;
			pad_n    = '0;
		end

		case (phase_n)
			PH_HEADER: begin
				shift_n = {byte_s1, shift_n[31:8]};
				if (idx_n == OFS_SIG && shift_n[31:16] != 16'h4D42) begin
					if (stat_n == ST_OK) stat_n = ST_BAD_SIG;
				end else if (idx_n == OFS_HSIZE && shift_n != 32'd40) begin
					if (stat_n == ST_OK) stat_n = ST_BAD_HSIZE;
				end else if (idx_n == OFS_WIDTH) begin
					width_n = (shift_n >= 32'd1 && shift_n <= 32'(MAX_WIDTH))
						? WW'(shift_n) : '0;
				end else if (idx_n == OFS_HEIGHT) begin
					height_n = (shift_n >= 32'd1 && shift_n <= 32'(MAX_HEIGHT))
						? HW'(shift_n) : '0;
				end else if (idx_n == OFS_PLANES) begin
					plane_n = (shift_n[31:16] != 16'd1);
				end else if (idx_n == OFS_DEPTH && shift_n[31:16] != 16'd24) begin
					if (stat_n == ST_OK) stat_n = ST_BAD_DEPTH;
				end else if (idx_n == OFS_COMPR && shift_n != 32'd0) begin
					if (stat_n == ST_OK) stat_n = ST_COMPRESS;
				end

				if (idx_n < OFS_LAST) begin
					idx_n = idx_n + 6'd1;
				end else begin
					if ((width_n == '0 || height_n == '0) && stat_n == ST_OK)
						stat_n = ST_BAD_DIM;
					produce  = 1'b1;
					r_kind   = EV_HEADER;
					r_status = stat_n;
					r_plane  = plane_n;
					phase_n  = (stat_n == ST_OK) ? PH_PIXELS : PH_DONE;
					comp_n   = '0;
					col_n    = '0;
					row_n    = '0;
					pad_n    = '0;
				end
			end
			PH_PIXELS: begin
				if (pad_n != 2'd0) begin
					pad_n = pad_n - 2'd1;
				end else if (comp_n == 2'd0) begin
					blue_n = byte_s1;
					comp_n = 2'd1;
				end else if (comp_n == 2'd1) begin
					green_n = byte_s1;
					comp_n  = 2'd2;
				end else begin
					produce = 1'b1;
					r_kind  = EV_PIXEL;
					r_red   = byte_s1;
					r_green = green_q;
					r_blue  = blue_q;
					r_row   = row_q;
					r_col   = col_q;
					r_last  = (row_inc == CW'(height_q)) && (col_inc == CW'(width_q));
					comp_n  = 2'd0;
					if (r_last) begin
						phase_n = PH_DONE;
					end else if (col_inc >= CW'(width_q)) begin
						col_n = '0;
						row_n = POS_W'(row_inc);
						// Row bytes are 3*width, so the pad to a multiple of 4 is width mod 4.
						pad_n = 2'(width_q);
					end else begin
						col_n = POS_W'(col_inc);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			idx_q    <= '0;
			shift_q  <= '0;
			stat_q   <= ST_OK;
			plane_q  <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			comp_q   <= '0;
			blue_q   <= '0;
			green_q  <= '0;
			col_q    <= '0;
			row_q    <= '0;
			pad_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			shift_q  <= shift_n;
			stat_q   <= stat_n;
			plane_q  <= plane_n;
			width_q  <= width_n;
			height_q <= height_n;
			comp_q   <= comp_n;
			blue_q   <= blue_n;
			green_q  <= green_n;
			col_q    <= col_n;
			row_q    <= row_n;
			pad_q    <= pad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= produce;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			event_kind     <= r_kind;
			status_code    <= r_status;
			planes_warning <= r_plane;
			red            <= r_red;
			green          <= r_green;
			blue           <= r_blue;
			pixel_row      <= r_row;
			pixel_column   <= r_col;
			last_pixel     <= r_last;
		end
	end

	`BMP_ASSERT_NOW(a_pixel_clean, result_valid && event_kind == EV_PIXEL, status_code == ST_OK && !planes_warning)
	`BMP_ASSERT_NEXT(a_last_ends, advance && produce && r_kind == EV_PIXEL && r_last, phase_q == PH_DONE)
	`BMP_ASSERT_NEXT(a_hdr_ok_pixels, advance && produce && r_kind == EV_HEADER && r_status == ST_OK, phase_q == PH_PIXELS)
	`BMP_ASSERT_NOW(a_col_in_range, phase_q == PH_PIXELS, CW'(col_q) < CW'(width_q))

endmodule
